// ===== rtl/nwni_pkg.sv =====
// Package for the nearest waypoint search block.
// Holds the input and result word types, function codes and the
// command and status bundles between controller and datapath.
package nwni_pkg;

    // Fixed field widths of the channel words
    localparam int FIELD_W = 24;
    localparam int SLOT_W  = 10;
    localparam int CNT_W   = 11;

    // Function codes of an input word
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [SLOT_W-1:0]         wp_index;
        logic signed [FIELD_W-1:0] wp_x;
        logic signed [FIELD_W-1:0] wp_y;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic                      found;
        logic [SLOT_W-1:0]         target_index;
        logic signed [FIELD_W-1:0] target_x;
        logic signed [FIELD_W-1:0] target_y;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;      // write the input word's waypoint into the table
        logic query_start;  // capture the query position
        logic scan_rd;      // read the table at the scan address
        logic scan_first;   // this read is entry zero
        logic fetch;        // read the target entry
        logic out_load;     // load the result register
        logic out_found;    // result carries a waypoint
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;    // distance pipeline still holds entries
    } t_dp_stat;

endpackage

// ===== rtl/nearest_waypoint_next_index.sv =====
// Top level of the nearest waypoint search with next-index selection.
// Depends on nwni_pkg, nwni_ctrl and nwni_dp.
//
//  channel  handshake                  payload
//  ------   -------------------------  -----------------------
//  cfg      i_cfg_we                   i_cfg_wdata (waypoint count)
//  in       i_in_valid / o_in_ready    i_in_word  (t_in_word)
//  out      o_out_valid / i_out_ready  o_out_word (t_out_word)
//
// A load word is written into the table and gives no result. A query scans
// every entry in use through the single table read port, one read per entry,
// then fetches the target entry; with no entry in use it goes to the result.
// Reset is synchronous and active low; it clears the count and all control.
// The next word is accepted while a result still waits in the output register;
// a stalled output holds a finished query in its last state.
module nearest_waypoint_next_index #(
    parameter int MAX_WAYPOINTS = 1024,
    parameter int COORD_BITS    = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [nwni_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  nwni_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output nwni_pkg::t_out_word        o_out_word
);
    import nwni_pkg::*;

    localparam int IW = $clog2(MAX_WAYPOINTS);
    localparam int CW = IW + 1;

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [IW-1:0] scan_addr;
    logic [CW-1:0] count;

    // Sequence loads and queries
    nwni_ctrl #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_func   (i_in_word.func),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat),
        .o_scan_addr (scan_addr),
        .o_count     (count)
    );

    // Table, distance pipeline and result
    nwni_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_scan_addr (scan_addr),
        .i_count     (count),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/nwni_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nwni_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nwni_ctrl.sv =====
// Controller of the nearest waypoint search: state machine, count register,
// scan counter and output valid. Depends on nwni_pkg.
module nwni_ctrl #(
    parameter int MAX_WAYPOINTS = 1024,
    localparam int IW = $clog2(MAX_WAYPOINTS),
    localparam int CW = IW + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nwni_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_func,
    output logic                      o_in_ready,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output nwni_pkg::t_dp_cmd         o_cmd,
    input  nwni_pkg::t_dp_stat        i_stat,
    output logic [IW-1:0]             o_scan_addr,
    output logic [CW-1:0]             o_count
);
    import nwni_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_waypoint_count;
    logic [IW-1:0]    r_addr, n_addr;
    logic [CW-1:0]    r_n, n_n;
    logic             r_empty, n_empty;
    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    count_eff;
    logic             in_acc;
    logic             out_free;
    logic [CW-1:0]    last_addr;

    // Clamp the count register to the table depth
    assign count_eff = (32'(r_waypoint_count) > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS)
                                                               : CW'(r_waypoint_count);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign last_addr  = r_n - 1'b1;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_n         = r_n;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_func == FUNC_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.query_start = 1'b1;
                        n_n    = count_eff;
                        n_addr = '0;
                        if (count_eff == '0) begin
                            n_empty = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_empty = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd    = 1'b1;
                o_cmd.scan_first = (r_addr == '0);
                if (CW'(r_addr) == last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_found = !r_empty;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_waypoint_count <= '0;
            r_addr           <= '0;
            r_n              <= '0;
            r_empty          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_n         <= n_n;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_waypoint_count <= i_cfg_wdata;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scan_addr = r_addr;
    assign o_count     = r_n;

endmodule

// ===== rtl/nwni_dp.sv =====
// Datapath of the nearest waypoint search: waypoint table, distance pipeline,
// running minimum, target selection and result register.
// Depends on nwni_pkg and nwni_ram.
module nwni_dp #(
    parameter int MAX_WAYPOINTS = 1024,
    parameter int COORD_BITS    = 24,
    localparam int IW = $clog2(MAX_WAYPOINTS),
    localparam int CW = IW + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nwni_pkg::t_in_word  i_in_word,
    input  nwni_pkg::t_dp_cmd   i_cmd,
    output nwni_pkg::t_dp_stat  o_stat,
    input  logic [IW-1:0]       i_scan_addr,
    input  logic [CW-1:0]       i_count,
    output nwni_pkg::t_out_word o_out_word
);
    import nwni_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int SW = 2 * CB + 1;
    localparam int DW = (SW > 64) ? 64 : SW;

    logic signed [31:0]  wx_ext, wy_ext, px_ext, py_ext;
    logic                slot_ok;
    logic [IW-1:0]       waddr;
    logic [2*CB-1:0]     wdata;
    logic                re;
    logic [IW-1:0]       raddr;
    logic [2*CB-1:0]     rdata;
    logic [CB-1:0]       rd_x, rd_y;

    logic [CB-1:0]       r_px, r_py;
    logic                r_p1_v, r_p2_v, r_p3_v;
    logic                r_p1_first, r_p2_first, r_p3_first;
    logic [IW-1:0]       r_p1_idx, r_p2_idx, r_p3_idx;
    logic signed [CB:0]  dx, dy;
    logic [CB:0]         adx_full, ady_full;
    logic [CB-1:0]       r_adx, r_ady;
    logic [2*CB-1:0]     r_sqx, r_sqy;
    logic [SW-1:0]       sum_full;
    logic [DW-1:0]       dist_sq;
    logic [DW-1:0]       r_best_d;
    logic [IW-1:0]       r_best_idx;
    logic [CW-1:0]       next_idx, last_idx;
    logic [IW-1:0]       target;
    logic [IW-1:0]       r_target;
    logic signed [31:0]  tx_ext, ty_ext;
    t_out_word           r_out;

    // Wrap incoming coordinates to the table width
    assign wx_ext  = 32'(i_in_word.wp_x);
    assign wy_ext  = 32'(i_in_word.wp_y);
    assign px_ext  = 32'(i_in_word.pos_x);
    assign py_ext  = 32'(i_in_word.pos_y);
    assign slot_ok = 32'(i_in_word.wp_index) < MAX_WAYPOINTS;
    assign waddr   = IW'(i_in_word.wp_index);
    assign wdata   = {wy_ext[CB-1:0], wx_ext[CB-1:0]};

    // Target slot: entry after the nearest, clamped to the last in use
    assign next_idx = CW'(r_best_idx) + 1'b1;
    assign last_idx = i_count - 1'b1;
    assign target   = (next_idx < i_count) ? next_idx[IW-1:0] : last_idx[IW-1:0];

    assign re    = i_cmd.scan_rd || i_cmd.fetch;
    assign raddr = i_cmd.fetch ? target : i_scan_addr;

    nwni_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && slot_ok),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_x = rdata[CB-1:0];
    assign rd_y = rdata[2*CB-1:CB];

    // Stage 1: absolute coordinate differences
    assign dx = $signed({r_px[CB-1], r_px}) - $signed({rd_x[CB-1], rd_x});
    assign dy = $signed({r_py[CB-1], r_py}) - $signed({rd_y[CB-1], rd_y});
    assign adx_full = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
    assign ady_full = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);

    // Stage 3: squared distance, saturated to 64 bits where it can overflow
    assign sum_full = {1'b0, r_sqx} + {1'b0, r_sqy};
    generate
        if (SW > 64) begin : g_sat
            assign dist_sq = sum_full[SW-1] ? {DW{1'b1}} : sum_full[DW-1:0];
        end else begin : g_exact
            assign dist_sq = sum_full;
        end
    endgenerate

    assign o_stat.pipe_busy = r_p1_v || r_p2_v || r_p3_v;

    // Pipeline valid tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.scan_rd;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    // Pipeline payload and running minimum
    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_px <= px_ext[CB-1:0];
            r_py <= py_ext[CB-1:0];
        end
        r_p1_first <= i_cmd.scan_first;
        r_p1_idx   <= i_scan_addr;
        r_p2_first <= r_p1_first;
        r_p2_idx   <= r_p1_idx;
        r_p3_first <= r_p2_first;
        r_p3_idx   <= r_p2_idx;
        r_adx      <= adx_full[CB-1:0];
        r_ady      <= ady_full[CB-1:0];
        r_sqx      <= r_adx * r_adx;
        r_sqy      <= r_ady * r_ady;
        // Keep the lowest index on a tie
        if (r_p3_v && (r_p3_first || dist_sq < r_best_d)) begin
            r_best_d   <= dist_sq;
            r_best_idx <= r_p3_idx;
        end
        if (i_cmd.fetch) begin
            r_target <= target;
        end
    end

    // Result register
    assign tx_ext = 32'(signed'(rd_x));
    assign ty_ext = 32'(signed'(rd_y));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_found) begin
                r_out.found        <= 1'b1;
                r_out.target_index <= SLOT_W'(r_target);
                r_out.target_x     <= tx_ext[FIELD_W-1:0];
                r_out.target_y     <= ty_ext[FIELD_W-1:0];
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== sim/tb_nearest_waypoint_next_index.sv =====
// Testbench for nearest_waypoint_next_index: waypoint loads and position queries
// checked word by word against a predictor of the search. Needs nwni_pkg and the RTL.
`timescale 1ns / 1ps

module tb_nearest_waypoint_next_index;
    import nwni_pkg::*;

    localparam int MAX_WP           = 1024;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 16;
    localparam int DRAIN_CYCLES     = 40;
    localparam int QUIET_LIMIT      = 20000;
    localparam int HOLD_CYCLES      = 600;
    localparam int ITEMS_PER_REGIME = 195;

    localparam logic signed [FIELD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [FIELD_W-1:0] C_MIN = 24'sh800000;
    localparam t_out_word NO_TARGET = '0;

    typedef enum logic [1:0] {ROW_SET, ROW_LOAD, ROW_QUERY} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CNT_W-1:0]          arg;    // count for a setting, slot for a load
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic                      typed;  // want holds a hand-written result
        t_out_word                 want;
    } t_plan_row;

    typedef struct packed {
        logic      typed;
        t_out_word want;
    } t_word_note;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_word         in_word   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_word;

    // Predictor state: waypoint table and count in use
    logic signed [FIELD_W-1:0] x_tab [MAX_WP];
    logic signed [FIELD_W-1:0] y_tab [MAX_WP];
    logic [CNT_W-1:0]          count_setting = '0;

    t_out_word  pending_targets [$];
    t_word_note word_notes [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    bit hold_out_req    = 1'b0;
    int words_offered   = 0;
    int words_taken     = 0;
    int loads_seen      = 0;
    int queries_seen    = 0;
    int results_checked = 0;
    int settings_done   = 0;
    int long_holds      = 0;
    int fails           = 0;

    // Directed rows: empty table, extremes, ties, clamping to the last entry
    t_plan_row dir_plan [0:19] = '{
        '{ROW_SET,   11'd0,    24'sd0, 24'sd0,     1'b0, NO_TARGET},
        '{ROW_QUERY, 11'd0,    24'sd0, 24'sd0,     1'b1, NO_TARGET},
        '{ROW_QUERY, 11'd0,    C_MAX,  C_MIN,      1'b1, NO_TARGET},
        '{ROW_LOAD,  11'd0,    C_MAX,  C_MAX,      1'b0, NO_TARGET},
        '{ROW_LOAD,  11'd1,    C_MIN,  C_MIN,      1'b0, NO_TARGET},
        '{ROW_LOAD,  11'd2,    24'sd0, 24'sd0,     1'b0, NO_TARGET},
        '{ROW_LOAD,  11'd3,    24'sd0, 24'sd0,     1'b0, NO_TARGET},
        '{ROW_LOAD,  11'd1023, 24'sd1, -24'sd1,    1'b0, NO_TARGET},
        '{ROW_SET,   11'd1,    24'sd0, 24'sd0,     1'b0, NO_TARGET},
        '{ROW_QUERY, 11'd0,    C_MIN,  C_MIN,      1'b1, '{1'b1, 10'd0, C_MAX, C_MAX}},
        '{ROW_SET,   11'd4,    24'sd0, 24'sd0,     1'b0, NO_TARGET},
        '{ROW_QUERY, 11'd0,    C_MAX,  C_MAX,      1'b1, '{1'b1, 10'd1, C_MIN, C_MIN}},
        '{ROW_QUERY, 11'd0,    C_MIN,  C_MIN,      1'b1, '{1'b1, 10'd2, 24'sd0, 24'sd0}},
        '{ROW_QUERY, 11'd0,    24'sd0, 24'sd0,     1'b1, '{1'b1, 10'd3, 24'sd0, 24'sd0}},
        '{ROW_QUERY, 11'd0,    C_MIN,  C_MAX,      1'b0, NO_TARGET},
        '{ROW_QUERY, 11'd0,    24'sd1, 24'sd1,     1'b0, NO_TARGET},
        '{ROW_LOAD,  11'd3,    C_MAX,  C_MAX - 24'sd1, 1'b0, NO_TARGET},
        '{ROW_QUERY, 11'd0,    C_MAX,  C_MAX - 24'sd1, 1'b1,
          '{1'b1, 10'd3, C_MAX, C_MAX - 24'sd1}},
        '{ROW_SET,   11'd2,    24'sd0, 24'sd0,     1'b0, NO_TARGET},
        '{ROW_QUERY, 11'd0,    24'sd0, 24'sd0,     1'b0, NO_TARGET}
    };

    nearest_waypoint_next_index dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #4 clk = ~clk;

    // Squared distance scan; lowest index wins a tie, then step to the next entry
    function automatic t_out_word nearest_next_target(input logic signed [FIELD_W-1:0] px,
                                                      input logic signed [FIELD_W-1:0] py);
        t_out_word       tgt;
        longint          dx, dy;
        longint unsigned sq_sum, best_dist;
        int              n, best, pick;
        tgt = NO_TARGET;
        n = (count_setting > MAX_WP) ? MAX_WP : int'(count_setting);
        if (n == 0)
            return tgt;
        best      = 0;
        best_dist = 0;
        for (int i = 0; i < n; i++) begin
            dx = longint'(px) - longint'(x_tab[i]);
            dy = longint'(py) - longint'(y_tab[i]);
            // 24-bit coordinates keep the sum far below 64 bits
            sq_sum = longint'(dx * dx) + longint'(dy * dy);
            if (i == 0 || sq_sum < best_dist) begin
                best_dist = sq_sum;
                best      = i;
            end
        end
        pick = (best + 1 < n) ? best + 1 : n - 1;
        tgt.found        = 1'b1;
        tgt.target_index = SLOT_W'(pick);
        tgt.target_x     = x_tab[pick];
        tgt.target_y     = y_tab[pick];
        return tgt;
    endfunction

    function automatic t_in_word junk_word();
        logic [127:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom};
        return junk[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word make_load(input int slot, input logic signed [FIELD_W-1:0] x,
                                           input logic signed [FIELD_W-1:0] y);
        t_in_word w;
        w          = junk_word();
        w.func     = FUNC_LOAD;
        w.wp_index = SLOT_W'(slot);
        w.wp_x     = x;
        w.wp_y     = y;
        return w;
    endfunction

    function automatic t_in_word make_query(input logic signed [FIELD_W-1:0] x,
                                            input logic signed [FIELD_W-1:0] y);
        t_in_word w;
        w       = junk_word();
        w.func  = FUNC_QUERY;
        w.pos_x = x;
        w.pos_y = y;
        return w;
    endfunction

    // Tight coordinates cluster near the origin so that ties are common
    function automatic logic signed [FIELD_W-1:0] pick_coord(input bit tight);
        int v;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (tight) begin
            v = int'($urandom_range(0, 32)) - 16;
            return FIELD_W'(v);
        end
        if (r == 0)
            return C_MAX;
        if (r == 1)
            return C_MIN;
        return FIELD_W'($urandom_range(0, 24'hFFFFFF));
    endfunction

    // Extremes first, then mostly small counts
    function automatic logic [CNT_W-1:0] pick_count(input int phase_no);
        logic [CNT_W-1:0] opening [6];
        int unsigned      r;
        opening = '{11'd1024, 11'd0, 11'd1, 11'd2047, 11'd1023, 11'd1025};
        r = $urandom_range(0, 99);
        if (phase_no < 6)
            return opening[phase_no];
        if (r < 8)
            return '0;
        if (r < 14)
            return 11'd1;
        if (r < 70)
            return CNT_W'($urandom_range(2, 32));
        if (r < 88)
            return CNT_W'($urandom_range(33, 300));
        if (r < 94)
            return CNT_W'($urandom_range(301, 1024));
        return CNT_W'($urandom_range(1025, 2047));
    endfunction

    // Offer one word and hold it until accepted; valid stays high on return
    task automatic offer_word(input t_in_word w, input logic typed, input t_out_word want);
        t_word_note note;
        note.typed = typed;
        note.want  = want;
        word_notes.insert(word_notes.size(), note);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_offered++;
    endtask

    // Drop valid and wait until every word is taken and every result is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (words_taken != words_offered || pending_targets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        count_setting  = value;
        settings_done++;
    endtask

    // Update the table on loads, queue the expected target on queries
    always @(posedge clk) begin
        t_word_note note;
        t_out_word  want_word;
        if (rst_n && in_valid && in_ready) begin
            note = word_notes.pop_front();
            words_taken++;
            if (in_word.func == FUNC_LOAD) begin
                x_tab[in_word.wp_index] = in_word.wp_x;
                y_tab[in_word.wp_index] = in_word.wp_y;
                loads_seen++;
            end else begin
                want_word = note.typed ? note.want
                                       : nearest_next_target(in_word.pos_x, in_word.pos_y);
                pending_targets.insert(pending_targets.size(), want_word);
                queries_seen++;
            end
        end
    end

    // Compare each result word with the oldest expected target
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_targets.size() == 0) begin
                $error("result word with no query pending: %p", out_word);
                fails++;
            end else begin
                want = pending_targets.pop_front();
                results_checked++;
                if (out_word.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, out_word.found);
                    fails++;
                end
                if (out_word.target_index !== want.target_index) begin
                    $error("target_index: expected %0d, got %0d",
                           want.target_index, out_word.target_index);
                    fails++;
                end
                if (out_word.target_x !== want.target_x) begin
                    $error("target_x: expected %0d, got %0d",
                           $signed(want.target_x), $signed(out_word.target_x));
                    fails++;
                end
                if (out_word.target_y !== want.target_y) begin
                    $error("target_y: expected %0d, got %0d",
                           $signed(want.target_y), $signed(out_word.target_y));
                    fails++;
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                out_ready <= 1'b0;
            end else if (hold_out_req) begin
                out_ready    <= 1'b0;
                hold_out_req  = 1'b0;
                long_holds++;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run after too many cycles with no transfer at all
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL nearest_waypoint_next_index");
        $finish;
    end

    // Stimulus
    initial begin
        int                        regime, phase_no, regime_items, len, n_eff, load_pct;
        int                        k, s;
        int                        off;
        bit                        tight, hold_phase;
        logic [CNT_W-1:0]          count_now;
        logic signed [FIELD_W-1:0] px, py;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 75;

        // Walk the directed rows
        foreach (dir_plan[r]) begin
            case (dir_plan[r].kind)
                ROW_SET: begin
                    wait_idle();
                    write_count(dir_plan[r].arg);
                end
                ROW_LOAD: begin
                    offer_word(make_load(int'(dir_plan[r].arg), dir_plan[r].x, dir_plan[r].y),
                               1'b0, NO_TARGET);
                end
                default: begin
                    offer_word(make_query(dir_plan[r].x, dir_plan[r].y),
                               dir_plan[r].typed, dir_plan[r].want);
                end
            endcase
        end

        // Fill every slot so that any count reads written entries only
        for (s = 0; s < MAX_WP; s++)
            offer_word(make_load(s, pick_coord(1'b0), pick_coord(1'b0)), 1'b0, NO_TARGET);

        phase_no = 0;
        for (regime = 0; regime < 3; regime++) begin
            send_idle_pct = (regime == 0) ? 18 : (regime == 1) ? 75 : 0;
            recv_idle_pct = (regime == 0) ? 75 : (regime == 1) ? 18 : 0;
            regime_items  = 0;
            hold_phase    = (regime == 2);
            while (regime_items < ITEMS_PER_REGIME) begin
                count_now = hold_phase ? CNT_W'($urandom_range(1, 8)) : pick_count(phase_no);
                phase_no++;
                wait_idle();
                write_count(count_now);
                n_eff    = (count_now > MAX_WP) ? MAX_WP : int'(count_now);
                tight    = (n_eff >= 1 && n_eff <= 32 && !hold_phase &&
                            $urandom_range(0, 3) == 0);
                len      = (n_eff > 300) ? $urandom_range(2, 4) : $urandom_range(10, 24);
                load_pct = hold_phase ? 0 : 30;
                // Block the output while queries keep coming, so the input backs up
                if (hold_phase)
                    hold_out_req = 1'b1;

                // Rewrite the entries in use with clustered points
                if (tight) begin
                    for (s = 0; s < n_eff; s++) begin
                        offer_word(make_load(s, pick_coord(1'b1), pick_coord(1'b1)),
                                   1'b0, NO_TARGET);
                        regime_items++;
                    end
                end

                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 99) < load_pct) begin
                        s = (n_eff > 0 && $urandom_range(0, 99) < 70) ?
                            $urandom_range(0, n_eff - 1) : $urandom_range(0, MAX_WP - 1);
                        if (n_eff > 0 && $urandom_range(0, 99) < 15) begin
                            // duplicate an entry in use to force a tie
                            off = $urandom_range(0, n_eff - 1);
                            px  = x_tab[off];
                            py  = y_tab[off];
                        end else begin
                            px = pick_coord(tight);
                            py = pick_coord(tight);
                        end
                        offer_word(make_load(s, px, py), 1'b0, NO_TARGET);
                    end else begin
                        if (n_eff > 0 && $urandom_range(0, 99) < 40) begin
                            // land on or just beside an entry in use
                            s   = $urandom_range(0, n_eff - 1);
                            off = int'($urandom_range(0, 6)) - 3;
                            px  = x_tab[s] + FIELD_W'(off);
                            off = int'($urandom_range(0, 6)) - 3;
                            py  = y_tab[s] + FIELD_W'(off);
                        end else begin
                            px = pick_coord(tight);
                            py = pick_coord(tight);
                        end
                        offer_word(make_query(px, py), 1'b0, NO_TARGET);
                    end
                    regime_items++;
                end
                hold_phase = 1'b0;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d queries over %0d count settings, 0 to 2047.",
                 loads_seen, queries_seen, settings_done);
        $display("Checked %0d results; %0d long output hold-off(s) with the input backed up.",
                 results_checked, long_holds);
        if (fails == 0 && pending_targets.size() == 0) begin
            $display("PASS nearest_waypoint_next_index");
        end else begin
            $display("FAIL nearest_waypoint_next_index");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nwni_pkg.sv
rtl/nwni_ram.sv
rtl/nwni_ctrl.sv
rtl/nwni_dp.sv
rtl/nearest_waypoint_next_index.sv
sim/tb_nearest_waypoint_next_index.sv
